/* hdl/assert_macros.svh */
// assertion macros shared by the meter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/trwm_pkg.sv */
// types, constants and command codes of the transfer rate window meter
package trwm_pkg;

	// history depth and derived widths
	localparam int HISTORY_DEPTH = 10;
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
	localparam int IDX_W         = $clog2(HISTORY_DEPTH);

	// command codes
	localparam logic [2:0] CMD_ADD      = 3'd0;
	localparam logic [2:0] CMD_ROLLBACK = 3'd1;
	localparam logic [2:0] CMD_QUERY    = 3'd2;
	localparam logic [2:0] CMD_SUSPEND  = 3'd3;
	localparam logic [2:0] CMD_RESUME   = 3'd4;

	// timing constants
	localparam logic [31:0] MS_PER_SEC   = 32'd1000;
	localparam logic [31:0] WRAP_SPAN_MS = 32'd10000;

	// saturation limits of the running total
	localparam logic signed [47:0] TOTAL_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] TOTAL_MIN = {1'b1, {47{1'b0}}};

	// divider sizing: one quotient bit a cycle
	localparam int DIV_STEPS = 32;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// input word
	typedef struct packed {
		logic [2:0]         command;
		logic [31:0]        now_ms;
		logic signed [47:0] amount;
	} req_word_t;

	// result word
	typedef struct packed {
		logic [31:0]        rate_bytes_per_sec;
		logic signed [47:0] total_bytes;
		logic [3:0]         sample_count;
	} rsp_word_t;

	// commands from controller to datapath
	typedef struct packed {
		logic cap_in;
		logic exec;
		logic prep;
		logic mul;
		logic div_init;
		logic div_step;
		logic load_out;
	} ctl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_query;
	} dp_sts_t;

endpackage

/* hdl/transfer_rate_window_meter.sv */
// Transfer rate window meter: one result word per input word. Add, rollback, suspend and
// resume words go from the execute state straight to the result; a rate query goes
// through a span/gain stage and a scale-by-1000 stage, then the restoring divider that
// forms one quotient bit a cycle over 32 steps. One word is worked on at a time; the
// next input word is taken as soon as the previous result sits in the output register,
// even while that result is still stalled. There is no clearing pass after reset.
module transfer_rate_window_meter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  trwm_pkg::req_word_t req_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output trwm_pkg::rsp_word_t rsp_word
);
	import trwm_pkg::*;

	ctl_cmd_t ctl_cmd;
	dp_sts_t  dp_sts;

	// controller
	trwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (ctl_cmd),
		.sts       (dp_sts)
	);

	// datapath
	trwm_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctl_cmd),
		.sts      (dp_sts),
		.req_word (req_word),
		.rsp_word (rsp_word)
	);

endmodule

/* hdl/trwm_dpath.sv */
// datapath of the meter: total, sample history, query arithmetic and divider
`include "assert_macros.svh"

module trwm_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  trwm_pkg::ctl_cmd_t  cmd,
	output trwm_pkg::dp_sts_t   sts,
	input  trwm_pkg::req_word_t req_word,
	output trwm_pkg::rsp_word_t rsp_word
);
	import trwm_pkg::*;

	// captured input word
	logic [2:0]         cmd_q;
	logic [31:0]        now_q;
	logic signed [47:0] amt_q;

	// meter state
	logic signed [47:0] total_q;
	logic [CNT_W-1:0]   count_q;
	logic [31:0]        stick_q;
	logic               susp_q;
	logic [31:0]        ofs_q;
	logic [31:0]        last_raw_q;
	logic [31:0]        tick_q [HISTORY_DEPTH];
	logic signed [47:0] stot_q [HISTORY_DEPTH];

	// query pipeline and divider
	logic [31:0]        span_q;
	logic [47:0]        gain_q;
	logic               skip_q;
	logic [57:0]        dvd_q;
	logic               sat_q;
	logic [31:0]        rem_q;
	logic [31:0]        quo_q;
	rsp_word_t          rsp_q;

	// saturating add and subtract of the total
	logic [48:0]        add_sum;
	logic [48:0]        sub_sum;
	logic signed [47:0] add_sat;
	logic signed [47:0] sub_sat;
	logic [31:0]        last_eff;
	logic [31:0]        since_last;
	logic               take;
	logic               full;

	assign add_sum = {total_q[47], total_q} + {amt_q[47], amt_q};
	assign sub_sum = {total_q[47], total_q} - {amt_q[47], amt_q};
	assign add_sat = (add_sum[48] != add_sum[47]) ? (add_sum[48] ? TOTAL_MIN : TOTAL_MAX)
	                                              : add_sum[47:0];
	assign sub_sat = (sub_sum[48] != sub_sum[47]) ? (sub_sum[48] ? TOTAL_MIN : TOTAL_MAX)
	                                              : sub_sum[47:0];

	// sample decision: empty history, clock wrap or a second gone by
	assign last_eff   = last_raw_q + ofs_q;
	assign since_last = now_q - last_eff;
	assign take       = (count_q == '0) || (last_eff > now_q) || (since_last >= MS_PER_SEC);
	assign full       = (count_q == CNT_W'(HISTORY_DEPTH));

	// query span and byte gain from the oldest sample
	logic [31:0] q_time;
	logic [31:0] tick0_eff;
	logic [31:0] span;
	logic [48:0] gain;

	assign q_time    = susp_q ? stick_q : now_q;
	assign tick0_eff = tick_q[0] + ofs_q;
	assign span      = (q_time < tick0_eff) ? WRAP_SPAN_MS : (q_time - tick0_eff);
	assign gain      = {total_q[47], total_q} - {stot_q[0][47], stot_q[0]};

	// gain times one thousand as shifts
	logic [57:0] gain_ext;
	logic [57:0] dvd;

	assign gain_ext = {10'd0, gain_q};
	assign dvd      = (gain_ext << 10) - (gain_ext << 4) - (gain_ext << 3);

	// one restoring division step
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, span_q};

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			cmd_q <= req_word.command;
			now_q <= req_word.now_ms;
			amt_q <= req_word.amount;
		end
	end

	// control-like state: total, count, suspend and tick offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
			stick_q <= '0;
			susp_q  <= 1'b0;
			ofs_q   <= '0;
		end else if (cmd.exec) begin
			case (cmd_q)
				CMD_ADD: begin
					total_q <= add_sat;
					if (amt_q[47]) begin
						count_q <= '0;
					end else if (take && !full) begin
						count_q <= count_q + 1'b1;
					end
				end
				CMD_ROLLBACK: begin
					total_q <= sub_sat;
					count_q <= '0;
				end
				CMD_SUSPEND: begin
					if (!susp_q) begin
						susp_q  <= 1'b1;
						stick_q <= now_q;
					end
				end
				CMD_RESUME: begin
					// shifting every held tick is one shift of the common offset
					if (susp_q) begin
						susp_q <= 1'b0;
						ofs_q  <= ofs_q + (now_q - stick_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// sample history, ticks stored relative to the offset
	always_ff @(posedge clk) begin
		if (cmd.exec && (cmd_q == CMD_ADD) && !amt_q[47] && take) begin
			last_raw_q <= now_q - ofs_q;
			if (full) begin
				for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
					tick_q[i] <= tick_q[i + 1];
					stot_q[i] <= stot_q[i + 1];
				end
				tick_q[HISTORY_DEPTH - 1] <= now_q - ofs_q;
				stot_q[HISTORY_DEPTH - 1] <= add_sat;
			end else begin
				tick_q[count_q[IDX_W-1:0]] <= now_q - ofs_q;
				stot_q[count_q[IDX_W-1:0]] <= add_sat;
			end
		end
	end

	// query preparation, scaling and division
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			span_q <= span;
			gain_q <= gain[47:0];
			skip_q <= (count_q == '0) || (span == '0) || gain[48] || (gain == '0);
		end
		if (cmd.mul) begin
			dvd_q <= dvd;
		end
		if (cmd.div_init) begin
			// a high part not below the divisor means the quotient needs over 32 bits
			sat_q <= ({6'd0, dvd_q[57:32]} >= span_q);
			rem_q <= {6'd0, dvd_q[57:32]};
			quo_q <= dvd_q[31:0];
		end else if (cmd.div_step) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd_q != CMD_QUERY || skip_q) begin
				rsp_q.rate_bytes_per_sec <= '0;
			end else if (sat_q) begin
				rsp_q.rate_bytes_per_sec <= '1;
			end else begin
				rsp_q.rate_bytes_per_sec <= quo_q;
			end
			rsp_q.total_bytes  <= total_q;
			rsp_q.sample_count <= 4'(count_q);
		end
	end

	assign rsp_word     = rsp_q;
	assign sts.is_query = (cmd_q == CMD_QUERY);

	`ASSERT_NEXT(a_rollback_clears, clk, arst_n, cmd.exec && (cmd_q == CMD_ROLLBACK), count_q == '0, "rollback left samples in the history")
	`ASSERT_NEXT(a_neg_add_clears, clk, arst_n, cmd.exec && (cmd_q == CMD_ADD) && amt_q[47], count_q == '0, "negative add left samples in the history")
	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(HISTORY_DEPTH), "sample count beyond history depth")

endmodule

/* hdl/trwm_ctrl.sv */
// controller state machine of the meter: sequencing, divider count and result handshake
`include "assert_macros.svh"

module trwm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output trwm_pkg::ctl_cmd_t cmd,
	input  trwm_pkg::dp_sts_t  sts
);
	import trwm_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EXEC  = 7'b0000010,
		S_PREP  = 7'b0000100,
		S_MUL   = 7'b0001000,
		S_DINIT = 7'b0010000,
		S_DSTEP = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [DCNT_W-1:0] dcnt_q;
	logic              rsp_valid_q;
	logic              accept;
	logic              out_free;

	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = S_EXEC;
			S_EXEC:  state_d = sts.is_query ? S_PREP : S_DONE;
			S_PREP:  state_d = S_MUL;
			S_MUL:   state_d = S_DINIT;
			S_DINIT: state_d = S_DSTEP;
			S_DSTEP: if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state, divider step count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DINIT) begin
				dcnt_q <= '0;
			end else if (state_q == S_DSTEP) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath commands
	assign cmd.cap_in   = accept;
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.prep     = (state_q == S_PREP);
	assign cmd.mul      = (state_q == S_MUL);
	assign cmd.div_init = (state_q == S_DINIT);
	assign cmd.div_step = (state_q == S_DSTEP);
	assign cmd.load_out = (state_q == S_DONE) && out_free;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	`ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == S_EXEC, "accepted word not executed next cycle")
	`ASSERT_NEXT(a_div_done, clk, arst_n, (state_q == S_DSTEP) && (dcnt_q == DCNT_W'(DIV_STEPS - 1)), state_q == S_DONE, "divider overran its step count")
	`ASSERT_NEXT(a_hold_result, clk, arst_n, (state_q == S_DONE) && rsp_valid_q && rsp_stall, (state_q == S_DONE) && rsp_valid_q, "waiting result word overwritten")

endmodule
